/* hdl/vlibd_pkg.sv */
// shared types and constants of the variable length integer bit decoder
// used by vlibd_ctrl, vlibd_dp and the top level; no dependencies
`timescale 1ns / 1ps

package vlibd_pkg;

  localparam int IN_W           = 8;
  localparam int VAL_W          = 32;
  localparam int ST_W           = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 6;
  localparam int FW_W           = 6;
  localparam int ZC_W           = 3;
  localparam int BITCNT_W       = 3;
  localparam int DEF_VALUE_BITS = 32;

  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_END = 2'd1;
  localparam logic [ST_W-1:0] ST_ERR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'd1;

  localparam logic [FW_W-1:0]     FW_RESET   = 6'd8;
  localparam logic [FW_W-1:0]     FW_MAX     = 6'd32;
  localparam logic [ZC_W-1:0]     ZERO_LIMIT = 3'd6;
  localparam logic [BITCNT_W-1:0] LAST_BIT   = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic flush;
  } vlibd_cmd_t;

  typedef struct packed {
    logic sticky;
    logic bit_err;
    logic step_ok;
    logic end_ok;
    logic flush_ok;
  } vlibd_sts_t;

endpackage

/* hdl/vlibd_ctrl.sv */
// decoder sequencer: takes a word, steps up to eight bits, then end and flush
// depends on vlibd_pkg
`timescale 1ns / 1ps

module vlibd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  vlibd_pkg::vlibd_sts_t sts,
  output vlibd_pkg::vlibd_cmd_t cmd
);
  import vlibd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BIT, S_END, S_FLUSH} state_t;

  state_t              state_r;
  logic                ready_r;
  logic [BITCNT_W-1:0] cnt_r;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_tvalid & ready_r;
    cmd.step   = (state_r == S_BIT) & sts.step_ok;
    cmd.finish = (state_r == S_END) & sts.end_ok;
    cmd.flush  = (state_r == S_FLUSH);
  end

  assign in_tready = ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.load) begin
            ready_r <= 1'b0;
            cnt_r   <= '0;
            state_r <= sts.sticky ? S_END : S_BIT;
          end
        end
        S_BIT: begin
          if (sts.step_ok) begin
            if (sts.bit_err || cnt_r == LAST_BIT) begin
              state_r <= S_END;
            end else begin
              cnt_r <= cnt_r + BITCNT_W'(1);
            end
          end
        end
        S_END: begin
          if (sts.end_ok) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (sts.flush_ok) begin
            state_r <= S_IDLE;
            ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* hdl/vlibd_dp.sv */
// datapath of the decoder: code state, one-bit decode step, end handling,
// pending result and output register; depends on vlibd_pkg
`timescale 1ns / 1ps

module vlibd_dp #(
  parameter int VALUE_BITS = vlibd_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vlibd_pkg::vlibd_cmd_t             cmd,
  output vlibd_pkg::vlibd_sts_t             sts,
  input  logic [vlibd_pkg::IN_W-1:0]        in_byte,
  input  logic                              in_fin,
  input  logic                              cfg_we,
  input  logic [vlibd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [vlibd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vlibd_pkg::VAL_W-1:0]       out_value,
  output logic [vlibd_pkg::ST_W-1:0]        out_status,
  output logic                              out_last
);
  import vlibd_pkg::*;

  localparam int LEN_W = $clog2(VALUE_BITS + 1);
  localparam int BL_W  = (LEN_W > FW_W) ? LEN_W : FW_W;

  typedef enum logic [1:0] {PH_PREFIX, PH_LENGTH, PH_VALUE, PH_FIXED} phase_t;

  // configuration
  logic            mode_r;
  logic [FW_W-1:0] fw_r;
  logic [FW_W-1:0] effw;

  // code state
  phase_t           ph_r;
  logic [ZC_W-1:0]  zc_r;
  logic [LEN_W-1:0] la_r;
  logic [BL_W-1:0]  bl_r;
  logic [VAL_W-1:0] va_r;
  logic             sticky_r;

  // word being decoded
  logic [IN_W-1:0]  sh_r;
  logic             fin_r;
  logic             skip_r;
  logic             err_r;

  // pending result and output register
  logic             pend_v_r;
  logic [VAL_W-1:0] pend_val_r;
  logic [ST_W-1:0]  pend_st_r;
  logic             out_v_r;
  logic [VAL_W-1:0] out_val_r;
  logic [ST_W-1:0]  out_st_r;
  logic             out_last_r;

  // bit step
  logic             cur_bit;
  logic [LEN_W:0]   lan;
  phase_t           b_ph;
  logic [ZC_W-1:0]  b_zc;
  logic [LEN_W-1:0] b_la;
  logic [BL_W-1:0]  b_bl;
  logic [VAL_W-1:0] b_va;
  logic             b_res;
  logic [VAL_W-1:0] b_val;
  logic             b_err;

  // end step
  phase_t           e_ph;
  logic [ZC_W-1:0]  e_zc;
  logic [LEN_W-1:0] e_la;
  logic [BL_W-1:0]  e_bl;
  logic [VAL_W-1:0] e_va;
  logic             e_res;
  logic [ST_W-1:0]  e_st;
  logic             e_err;

  logic             out_free;
  logic             new_res;
  logic [VAL_W-1:0] new_val;
  logic [ST_W-1:0]  new_st;

  always_comb begin
    if (fw_r == '0) begin
      effw = FW_W'(1);
    end else if (fw_r > FW_MAX) begin
      effw = FW_MAX;
    end else begin
      effw = fw_r;
    end
  end

  assign cur_bit = sh_r[IN_W-1];
  assign lan     = {la_r, cur_bit};

  always_comb begin
    b_ph  = ph_r;
    b_zc  = zc_r;
    b_la  = la_r;
    b_bl  = bl_r;
    b_va  = va_r;
    b_res = 1'b0;
    b_val = '0;
    b_err = 1'b0;
    if (mode_r) begin
      b_ph = PH_FIXED;
      if (ph_r != PH_FIXED) begin
        b_va = {{(VAL_W-1){1'b0}}, cur_bit};
        b_bl = BL_W'(effw) - BL_W'(1);
      end else begin
        b_va = {va_r[VAL_W-2:0], cur_bit};
        b_bl = bl_r - BL_W'(1);
      end
      if (b_bl == '0) begin
        b_res = 1'b1;
        b_val = b_va;
        b_ph  = PH_PREFIX;
        b_zc  = '0;
        b_la  = '0;
        b_va  = '0;
      end
    end else begin
      case (ph_r)
        PH_PREFIX: begin
          if (!cur_bit) begin
            if (zc_r >= ZERO_LIMIT) begin
              b_err = 1'b1;
            end else begin
              b_zc = zc_r + ZC_W'(1);
            end
          end else if (zc_r == '0) begin
            b_res = 1'b1;
            b_val = VAL_W'(1);
          end else begin
            b_ph = PH_LENGTH;
            b_bl = BL_W'(zc_r) + BL_W'(1);
            b_la = '0;
          end
        end
        PH_LENGTH: begin
          if (lan > (LEN_W+1)'(VALUE_BITS)) begin
            b_err = 1'b1;
          end else begin
            b_la = lan[LEN_W-1:0];
            b_bl = bl_r - BL_W'(1);
            if (b_bl == '0) begin
              if (lan == '0) begin
                b_res = 1'b1;
                b_ph  = PH_PREFIX;
                b_zc  = '0;
                b_la  = '0;
                b_va  = '0;
              end else begin
                b_ph = PH_VALUE;
                b_bl = BL_W'(lan[LEN_W-1:0]);
                b_va = '0;
              end
            end
          end
        end
        default: begin
          b_va = {va_r[VAL_W-2:0], cur_bit};
          b_bl = bl_r - BL_W'(1);
          if (b_bl == '0) begin
            b_res = 1'b1;
            b_val = b_va;
            b_ph  = PH_PREFIX;
            b_zc  = '0;
            b_la  = '0;
            b_va  = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    e_ph  = ph_r;
    e_zc  = zc_r;
    e_la  = la_r;
    e_bl  = bl_r;
    e_va  = va_r;
    e_res = 1'b0;
    e_st  = ST_OK;
    e_err = 1'b0;
    if (skip_r || err_r) begin
      e_res = 1'b1;
      e_st  = ST_ERR;
      e_err = 1'b1;
    end else if (fin_r) begin
      if (ph_r == PH_PREFIX) begin
        e_res = (zc_r != '0);
        e_st  = ST_END;
      end else begin
        e_res = 1'b1;
        e_st  = ST_ERR;
        e_err = 1'b1;
      end
    end
    if (skip_r || err_r || fin_r) begin
      e_ph = PH_PREFIX;
      e_zc = '0;
      e_la = '0;
      e_bl = '0;
      e_va = '0;
    end
  end

  assign out_free = !out_v_r || out_ready;
  assign new_res  = (cmd.step & b_res) | (cmd.finish & e_res);
  assign new_val  = cmd.finish ? VAL_W'(0) : b_val;
  assign new_st   = cmd.finish ? e_st : ST_OK;

  always_comb begin
    sts          = '0;
    sts.sticky   = sticky_r;
    sts.bit_err  = b_err;
    sts.step_ok  = !b_res || !pend_v_r || out_free;
    sts.end_ok   = !e_res || !pend_v_r || out_free;
    sts.flush_ok = !pend_v_r || out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      fw_r     <= FW_RESET;
      ph_r     <= PH_PREFIX;
      zc_r     <= '0;
      la_r     <= '0;
      bl_r     <= '0;
      va_r     <= '0;
      sticky_r <= 1'b0;
      fin_r    <= 1'b0;
      skip_r   <= 1'b0;
      err_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        sh_r   <= in_byte;
        fin_r  <= in_fin;
        skip_r <= sticky_r;
        err_r  <= 1'b0;
      end
      if (cmd.step) begin
        sh_r <= {sh_r[IN_W-2:0], 1'b0};
        ph_r <= b_ph;
        zc_r <= b_zc;
        la_r <= b_la;
        bl_r <= b_bl;
        va_r <= b_va;
        if (b_err) begin
          err_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        ph_r <= e_ph;
        zc_r <= e_zc;
        la_r <= e_la;
        bl_r <= e_bl;
        va_r <= e_va;
        if (e_err) begin
          sticky_r <= 1'b1;
        end
      end
      if (new_res) begin
        if (pend_v_r) begin
          out_v_r    <= 1'b1;
          out_val_r  <= pend_val_r;
          out_st_r   <= pend_st_r;
          out_last_r <= 1'b0;
        end else if (out_ready) begin
          out_v_r <= 1'b0;
        end
        pend_v_r   <= 1'b1;
        pend_val_r <= new_val;
        pend_st_r  <= new_st;
      end else if (cmd.flush && pend_v_r && out_free) begin
        out_v_r    <= 1'b1;
        out_val_r  <= pend_val_r;
        out_st_r   <= pend_st_r;
        out_last_r <= 1'b1;
        pend_v_r   <= 1'b0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MODE: begin
            mode_r <= cfg_wdata[0];
            ph_r   <= PH_PREFIX;
            zc_r   <= '0;
            la_r   <= '0;
            bl_r   <= '0;
            va_r   <= '0;
          end
          CFG_WIDTH: begin
            fw_r <= cfg_wdata[FW_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid  = out_v_r;
  assign out_value  = out_val_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;

endmodule

/* hdl/variable_length_integer_bit_decoder.sv */
// top level of the variable length integer bit decoder
// depends on vlibd_pkg, vlibd_ctrl and vlibd_dp
`timescale 1ns / 1ps

// Decodes a byte stream, most significant bit first, into integers: either a
// length-prefixed log code (zero run, length, value) or fixed-width fields of
// cfg width. The datapath decodes one bit per cycle while no result waits on a
// stalled result side. Each accepted word is taken, then goes through eight bit
// steps (fewer when an error ends the word early), one end step and one flush
// of the last result with tlast set; a word taken while the sticky error is set
// skips the bit steps. A word gives up to eight results; after a truncated or
// overlong code every word gives one error result until reset. The user must
// write configuration only while the block is idle; the block does not enforce it.

module variable_length_integer_bit_decoder #(
  parameter int VALUE_BITS = vlibd_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // data_byte
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vlibd_pkg::VAL_W-1:0]       out_tdata,  // decoded_value
  output logic [vlibd_pkg::ST_W-1:0]        out_tuser,  // status
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [vlibd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [vlibd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import vlibd_pkg::*;

  vlibd_cmd_t cmd;
  vlibd_sts_t sts;

  vlibd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vlibd_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .in_fin     (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

`ifndef SYNTH
  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero value with error status");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_END |-> out_tlast)
    else $error("end-of-data result without tlast");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a word was taken");
`endif

endmodule

/* bench/tb.sv */
// testbench for variable_length_integer_bit_decoder: drives coded byte streams in log and
// fixed-width mode, predicts every decoded word and checks the results in order
// depends on vlibd_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb;
  import vlibd_pkg::*;

  localparam logic MODE_LOG   = 1'b0;
  localparam logic MODE_FIXED = 1'b1;
  localparam int   SETTLE     = 20;
  localparam int   QUIET_MAX  = 5000;

  typedef enum logic [1:0] {SCAN_ZEROS, READ_LEN, READ_VAL, READ_FIELD} code_phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  status;
    logic             last;
  } result_t;

  typedef struct {
    logic          mode;
    logic [FW_W-1:0] width;
    code_phase_t   phase;
    int            zeros;
    int            len;
    int            remain;
    logic [63:0]   acc;
    logic          sticky;
  } dec_state_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // data_byte
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [VAL_W-1:0]      out_tdata;       // decoded_value
  logic [ST_W-1:0]       out_tuser;       // status
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dec_state_t dec;
  result_t    pending_results[$];
  int         words_in;
  int         mismatches;
  int         src_gap_pct;
  int         sink_gap_pct;
  int         hold_cycles;
  int         quiet_cycles;

  variable_length_integer_bit_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void restart_code(inout dec_state_t s);
    s.phase  = SCAN_ZEROS;
    s.zeros  = 0;
    s.len    = 0;
    s.remain = 0;
    s.acc    = '0;
  endfunction

  // bit-serial decode of one byte, msb first
  function automatic void decode_word(inout dec_state_t s, input logic [7:0] b,
                                      input logic fin, ref result_t rq[$]);
    int   first;
    logic err;
    logic bitv;
    first = rq.size();
    err   = 1'b0;
    if (s.sticky) begin
      rq.push_back('{'0, ST_ERR, 1'b1});
      return;
    end
    for (int i = 7; i >= 0 && !err; i--) begin
      bitv = b[i];
      if (s.mode == MODE_FIXED) begin
        if (s.phase != READ_FIELD) begin
          s.phase  = READ_FIELD;
          s.remain = (s.width == 0) ? 1 : (s.width > FW_MAX) ? FW_MAX : s.width;
          s.acc    = '0;
        end
        s.acc = {s.acc[62:0], bitv};
        s.remain--;
        if (s.remain == 0) begin
          rq.push_back('{s.acc[VAL_W-1:0], ST_OK, 1'b0});
          restart_code(s);
        end
      end else begin
        case (s.phase)
          SCAN_ZEROS: begin
            if (!bitv) begin
              if (s.zeros >= ZERO_LIMIT) err = 1'b1;
              else s.zeros++;
            end else if (s.zeros == 0) begin
              rq.push_back('{32'd1, ST_OK, 1'b0});
            end else begin
              s.phase  = READ_LEN;
              s.remain = s.zeros + 1;
              s.len    = 0;
            end
          end
          READ_LEN: begin
            s.len = s.len * 2 + bitv;
            if (s.len > DEF_VALUE_BITS) begin
              err = 1'b1;
            end else begin
              s.remain--;
              if (s.remain == 0) begin
                if (s.len == 0) begin
                  rq.push_back('{'0, ST_OK, 1'b0});
                  restart_code(s);
                end else begin
                  s.phase  = READ_VAL;
                  s.remain = s.len;
                  s.acc    = '0;
                end
              end
            end
          end
          default: begin
            s.acc = {s.acc[62:0], bitv};
            s.remain--;
            if (s.remain == 0) begin
              rq.push_back('{s.acc[VAL_W-1:0], ST_OK, 1'b0});
              restart_code(s);
            end
          end
        endcase
      end
    end
    if (!err && fin) begin
      if (s.phase == SCAN_ZEROS) begin
        if (s.zeros > 0) rq.push_back('{'0, ST_END, 1'b0});
      end else begin
        err = 1'b1;
      end
      restart_code(s);
    end
    if (err) begin
      s.sticky = 1'b1;
      restart_code(s);
      rq.push_back('{'0, ST_ERR, 1'b0});
    end
    if (rq.size() > first) rq[rq.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: %s mismatch at %0t, got %0h, expected %0h", field, $time, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [7:0] b, input logic fin);
    result_t fresh[$];
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    decode_word(dec, b, fin, fresh);
    foreach (fresh[i]) pending_results.push_back(fresh[i]);
    words_in++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) begin
      dec.mode = val[0];
      restart_code(dec);
    end else begin
      dec.width = val[FW_W-1:0];
    end
  endtask

  // zero run of n and a one, then (for n > 0) n+1 length bits and len value bits
  function automatic void add_code(ref bit q[$], input int n, input int len,
                                   input logic [31:0] val);
    repeat (n) q.push_back(1'b0);
    q.push_back(1'b1);
    if (n > 0) begin
      for (int i = n; i >= 0; i--) q.push_back(1'((len >> i) & 1));
      for (int i = len - 1; i >= 0; i--) q.push_back(val[i]);
    end
  endfunction

  function automatic void add_random_code(ref bit q[$]);
    int n;
    int maxl;
    n    = $urandom_range(6);
    maxl = (1 << (n + 1)) - 1;
    if (maxl > DEF_VALUE_BITS) maxl = DEF_VALUE_BITS;
    add_code(q, n, $urandom_range(maxl), $urandom);
  endfunction

  // pads to a byte with zeros (ends in the prefix) or ones (ends between codes)
  task automatic send_bits(ref bit q[$], input logic fin, input logic pad_zeros);
    logic [7:0] b;
    int r;
    if (pad_zeros) begin
      r = (8 - q.size() % 8) % 8;
      if (r == 7) begin
        q.push_back(1'b1);
        r = 6;
      end
      repeat (r) q.push_back(1'b0);
    end else begin
      while (q.size() % 8 != 0) q.push_back(1'b1);
    end
    while (q.size() != 0) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], q.pop_front()};
      send_word(b, fin && q.size() == 0);
    end
  endtask

  task automatic log_stream();
    bit   q[$];
    logic fin;
    repeat ($urandom_range(1, 6)) add_random_code(q);
    fin = 1'($urandom_range(1));
    send_bits(q, fin, fin && $urandom_range(1));
  endtask

  // marks a word final only where the field ends cleanly
  task automatic fixed_run(input int nbytes);
    dec_state_t probe;
    result_t    junk[$];
    logic [7:0] b;
    logic       fin;
    repeat (nbytes) begin
      b   = 8'($urandom);
      fin = 1'b0;
      if ($urandom_range(3) == 0) begin
        probe = dec;
        decode_word(probe, b, 1'b1, junk);
        fin = !probe.sticky;
      end
      send_word(b, fin);
    end
  endtask

  task automatic test_log_codes();
    bit q[$];
    add_code(q, 0, 0, 0);
    add_code(q, 1, 0, 0);
    add_code(q, 5, 32, 32'hFFFF_FFFF);
    add_code(q, 6, 1, 32'h1);
    add_code(q, 2, 5, 32'h15);
    send_bits(q, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_fixed_fields();
    cfg_write(CFG_MODE, CFG_DATA_W'(MODE_FIXED));
    cfg_write(CFG_WIDTH, 6'd0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);
    cfg_write(CFG_WIDTH, 6'd63);
    send_word(8'h80, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b1);
    // width change lands mid field
    cfg_write(CFG_WIDTH, 6'd5);
    send_word(8'hC3, 1'b0);
    cfg_write(CFG_WIDTH, 6'd3);
    send_word(8'h5A, 1'b1);
    // partial field dropped by mode change
    cfg_write(CFG_WIDTH, 6'd7);
    send_word(8'h81, 1'b0);
    cfg_write(CFG_WIDTH, FW_RESET);
    cfg_write(CFG_MODE, CFG_DATA_W'(MODE_LOG));
  endtask

  task automatic test_random_mix(input int words);
    int stop_log;
    int stop_all;
    logic [FW_W-1:0] w;
    stop_log = words_in + words * 3 / 5;
    stop_all = words_in + words;
    while (words_in < stop_log) log_stream();
    cfg_write(CFG_MODE, CFG_DATA_W'(MODE_FIXED));
    while (words_in < stop_all) begin
      case ($urandom_range(9))
        0:       w = FW_MAX;
        1:       w = FW_W'($urandom_range(63, 33));
        2:       w = 6'd0;
        default: w = FW_W'($urandom_range(1, 12));
      endcase
      cfg_write(CFG_WIDTH, w);
      fixed_run($urandom_range(4, 12));
    end
    cfg_write(CFG_MODE, CFG_DATA_W'(MODE_LOG));
  endtask

  task automatic test_backpressure();
    int stop;
    src_gap_pct = 0;
    hold_cycles = 300;
    stop = words_in + 20;
    while (words_in < stop) log_stream();
    wait_drained();
    repeat (4) log_stream();
  endtask

  task automatic test_sticky_error();
    bit q[$];
    cfg_write(CFG_MODE, CFG_DATA_W'(MODE_LOG));
    case ($urandom_range(3))
      0: begin
        // code cut off in its length or value bits
        add_code(q, 4, 20, $urandom);
        while (q.size() > 8 * $urandom_range(1, 2)) q.pop_back();
        while (q.size() % 8 != 0) q.pop_back();
        send_bits(q, 1'b1, 1'b0);
      end
      1: begin
        // length 33
        repeat (5) q.push_back(1'b0);
        q.push_back(1'b1);
        for (int i = 5; i >= 0; i--) q.push_back(1'((33 >> i) & 1));
        repeat (4) q.push_back(1'($urandom_range(1)));
        send_bits(q, 1'b0, 1'b0);
      end
      2: begin
        send_word(8'h00, 1'b0);
      end
      default: begin
        cfg_write(CFG_MODE, CFG_DATA_W'(MODE_FIXED));
        cfg_write(CFG_WIDTH, 6'd12);
        send_word(8'($urandom), 1'b1);
      end
    endcase
    repeat (10) send_word(8'($urandom), 1'($urandom_range(1)));
    cfg_write(CFG_MODE, CFG_DATA_W'(MODE_FIXED));
    cfg_write(CFG_WIDTH, 6'd1);
    repeat (4) send_word(8'($urandom), 1'($urandom_range(1)));
  endtask

  // result side with random stalls and long holds
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value) report_mismatch("value", out_tdata, want.value);
        if (out_tuser !== want.status) begin
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        end
        if (out_tlast !== want.last) begin
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    words_in     = 0;
    mismatches   = 0;
    hold_cycles  = 0;
    quiet_cycles = 0;
    src_gap_pct  = 29;
    sink_gap_pct = 79;
    dec.mode     = MODE_LOG;
    dec.width    = FW_RESET;
    dec.sticky   = 1'b0;
    restart_code(dec);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_log_codes();
    test_fixed_fields();
    test_random_mix(55);
    src_gap_pct  = 79;
    sink_gap_pct = 29;
    test_random_mix(55);
    test_backpressure();
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    test_random_mix(55);
    test_sticky_error();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
